[rtl/core/serial_loaded_bank_mapper_unit_defines.svh]
// ----------------------------------------------------------------------------
// Serial-loaded bank mapper: assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LOADED_BANK_MAPPER_UNIT_DEFINES_SVH
`define SERIAL_LOADED_BANK_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SBLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sblm: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SBLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sblm: next-cycle check failed");

`endif

[rtl/core/sblm_pkg.sv]
// ----------------------------------------------------------------------------
// sblm_pkg
// Widths, codes, command/status types and the remainder step shared by the
// serial-loaded bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package sblm_pkg;

  localparam int OP_W       = 2;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int MAP_W      = 22;
  localparam int MIR_W      = 3;
  localparam int PRG_CNT_W  = 8;
  localparam int CHR_CNT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int REG_W      = 5;
  localparam int WCNT_W     = 3;
  localparam int DIV_W      = 8;
  localparam int STEP_BITS  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CPU_RD = 2'd0,
    OP_CPU_WR = 2'd1,
    OP_PPU_RD = 2'd2,
    OP_PPU_WR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PRG,
    KIND_CHR8,
    KIND_CHR4,
    KIND_RAW
  } map_kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MIR   = 2'd2;

  localparam logic [PRG_CNT_W-1:0] PRG_COUNT_RESET = 8'd2;
  localparam logic [CHR_CNT_W-1:0] CHR_COUNT_RESET = 7'd0;
  localparam logic [MIR_W-1:0]     HDR_MIR_RESET   = 3'd3;

  // Internal register targets, chosen by address bits 14:13
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  localparam logic [REG_W-1:0]  CTRL_RESET     = 5'h0C;
  localparam logic [REG_W-1:0]  CTRL_PRG_MODE3 = 5'h0C;
  localparam logic [WCNT_W-1:0] LAST_SHIFT     = 3'd4;
  localparam logic [MIR_W-1:0]  MIR_FOUR       = 3'd4;

  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;

  typedef struct packed {
    logic capture;
    logic emit;
  } sblm_cmd_t;

  typedef struct packed {
    logic slot_free;
  } sblm_status_t;

  // Restoring remainder over STEP_BITS dividend bits, MSB first.
  function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0]     rem_in,
                                                input logic [STEP_BITS-1:0] bits,
                                                input logic [DIV_W-1:0]     divisor);
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    r = rem_in;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[DIV_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sblm_if.sv]
// ----------------------------------------------------------------------------
// sblm channel interfaces
// Valid/ready channels for bus accesses in and mapping results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sblm_in_if;
  import sblm_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;

  modport source (output valid, output operation, output address, output data,
                  input ready);
  modport sink   (input valid, input operation, input address, input data,
                  output ready);
endinterface

interface sblm_out_if;
  import sblm_pkg::*;
  logic             valid;
  logic             ready;
  logic             claimed;
  logic             address_valid;
  logic [MAP_W-1:0] mapped_address;
  logic [MIR_W-1:0] mirroring;

  modport source (output valid, output claimed, output address_valid,
                  output mapped_address, output mirroring, input ready);
  modport sink   (input valid, input claimed, input address_valid,
                  input mapped_address, input mirroring, output ready);
endinterface

`default_nettype wire

[rtl/core/sblm_ctrl.sv]
// ----------------------------------------------------------------------------
// sblm_ctrl
// Sequencer: takes a beat, then emits its result once the output slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sblm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  sblm_pkg::sblm_status_t status,
  output logic                  in_ready,
  output sblm_pkg::sblm_cmd_t    cmd
);
  import sblm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_EMIT;
            in_ready_r <= 1'b0;
          end
        end
        S_EMIT: begin
          // hold until the output register can take the result
          if (status.slot_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.capture = in_valid && in_ready_r;
    cmd.emit    = (state_r == S_EMIT) && status.slot_free;
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

[rtl/core/sblm_datapath.sv]
// ----------------------------------------------------------------------------
// sblm_datapath
// Config and mapper registers, access decode, two-step bank remainder and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sblm_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sblm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sblm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [sblm_pkg::OP_W-1:0]         in_operation,
  input  logic [sblm_pkg::ADDR_W-1:0]       in_address,
  input  logic [sblm_pkg::DATA_W-1:0]       in_data,
  input  sblm_pkg::sblm_cmd_t               cmd,
  output sblm_pkg::sblm_status_t            status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_claimed,
  output logic                              out_address_valid,
  output logic [sblm_pkg::MAP_W-1:0]        out_mapped_address,
  output logic [sblm_pkg::MIR_W-1:0]        out_mirroring
);
  import sblm_pkg::*;

  // configuration
  logic [PRG_CNT_W-1:0] prg_cnt_r;
  logic [CHR_CNT_W-1:0] chr_cnt_r;
  logic [MIR_W-1:0]     hdr_mir_r;

  // mapper state
  logic [REG_W-1:0]  shift_r;
  logic [WCNT_W-1:0] wcnt_r;
  logic [REG_W-1:0]  ctrl_r;
  logic [REG_W-1:0]  chr_lo_r;
  logic [REG_W-1:0]  chr_hi_r;
  logic [REG_W-1:0]  prg_sel_r;
  logic              ctrl_written_r;

  // job in flight
  map_kind_t             kind_r;
  logic                  claimed_r;
  logic                  bypass_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [STEP_BITS-1:0]  low_bits_r;
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      div_r;

  // output register
  logic                  out_valid_r;
  logic                  out_claimed_r;
  logic                  out_addr_valid_r;
  logic [MAP_W-1:0]      out_mapped_r;
  logic [MIR_W-1:0]      out_mir_r;

  // decode of the incoming beat
  op_t                     op;
  logic                    cpu_hit;
  logic                    ppu_lo;
  logic                    chr_ram;
  map_kind_t               kind_nxt;
  logic                    claimed_nxt;
  logic                    bypass_nxt;
  logic [REG_W-1:0]        bank_nxt;
  logic [DIV_W-1:0]        div_nxt;
  logic [2*STEP_BITS-1:0]  dividend;

  // serial load
  logic              wr_hit;
  logic [REG_W-1:0]  shift_v;

  // emit
  logic [DIV_W-1:0]  rem_final;
  logic [DIV_W-1:0]  bank_final;
  logic [MAP_W-1:0]  mapped_nxt;
  logic [MIR_W-1:0]  mir_nxt;

  assign op      = op_t'(in_operation);
  assign cpu_hit = in_address[ADDR_W-1] && (prg_cnt_r != '0);
  assign ppu_lo  = (in_address[ADDR_W-1:13] == '0);
  assign chr_ram = (chr_cnt_r == '0);

  always_comb begin
    kind_nxt    = KIND_NONE;
    claimed_nxt = 1'b0;
    bypass_nxt  = 1'b0;
    bank_nxt    = '0;
    div_nxt     = prg_cnt_r;
    case (op)
      OP_CPU_RD: begin
        if (cpu_hit) begin
          claimed_nxt = 1'b1;
          kind_nxt    = KIND_PRG;
          case (ctrl_r[3:2])
            2'd0, 2'd1: bank_nxt = {1'b0, prg_sel_r[3:1], in_address[14]};
            PRG_MODE_FIX_FIRST: begin
              bank_nxt = in_address[14] ? {1'b0, prg_sel_r[3:0]} : '0;
            end
            default: begin
              // fixed last bank above 0xC000
              if (in_address[14]) begin
                bypass_nxt = 1'b1;
              end else begin
                bank_nxt = {1'b0, prg_sel_r[3:0]};
              end
            end
          endcase
        end
      end
      OP_CPU_WR: begin
        claimed_nxt = cpu_hit;
      end
      OP_PPU_RD: begin
        if (ppu_lo) begin
          claimed_nxt = 1'b1;
          if (chr_ram) begin
            kind_nxt = KIND_RAW;
          end else if (!ctrl_r[4]) begin
            kind_nxt = KIND_CHR8;
            bank_nxt = {1'b0, chr_lo_r[4:1]};
            div_nxt  = {1'b0, chr_cnt_r};
          end else begin
            kind_nxt = KIND_CHR4;
            bank_nxt = in_address[12] ? chr_hi_r : chr_lo_r;
            div_nxt  = {chr_cnt_r, 1'b0};
          end
        end
      end
      OP_PPU_WR: begin
        if (ppu_lo && chr_ram) begin
          claimed_nxt = 1'b1;
          kind_nxt    = KIND_RAW;
        end
      end
      default: begin
        kind_nxt    = KIND_NONE;
        claimed_nxt = 1'b0;
      end
    endcase
  end

  assign dividend = {{(2*STEP_BITS-REG_W){1'b0}}, bank_nxt};

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_cnt_r <= PRG_COUNT_RESET;
      chr_cnt_r <= CHR_COUNT_RESET;
      hdr_mir_r <= HDR_MIR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_COUNT: prg_cnt_r <= cfg_wdata[PRG_CNT_W-1:0];
        CFG_CHR_COUNT: chr_cnt_r <= cfg_wdata[CHR_CNT_W-1:0];
        CFG_HDR_MIR:   hdr_mir_r <= cfg_wdata[MIR_W-1:0];
        default: ;
      endcase
    end
  end

  // serial register load on claimed CPU writes
  assign wr_hit  = cmd.capture && (op == OP_CPU_WR) && cpu_hit;
  assign shift_v = {in_data[0], shift_r[REG_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r        <= '0;
      wcnt_r         <= '0;
      ctrl_r         <= CTRL_RESET;
      chr_lo_r       <= '0;
      chr_hi_r       <= '0;
      prg_sel_r      <= '0;
      ctrl_written_r <= 1'b0;
    end else if (wr_hit) begin
      if (in_data[DATA_W-1]) begin
        shift_r <= '0;
        wcnt_r  <= '0;
        ctrl_r  <= ctrl_r | CTRL_PRG_MODE3;
      end else if (wcnt_r < LAST_SHIFT) begin
        shift_r <= shift_v;
        wcnt_r  <= wcnt_r + 1'b1;
      end else begin
        shift_r <= '0;
        wcnt_r  <= '0;
        case (in_address[14:13])
          SEL_CONTROL: begin
            ctrl_r         <= shift_v;
            ctrl_written_r <= 1'b1;
          end
          SEL_CHR_LOW:  chr_lo_r  <= shift_v;
          SEL_CHR_HIGH: chr_hi_r  <= shift_v;
          SEL_PRG:      prg_sel_r <= shift_v;
          default: ;
        endcase
      end
    end
  end

  // capture the beat and run the first remainder step
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= kind_nxt;
      claimed_r  <= claimed_nxt;
      bypass_r   <= bypass_nxt;
      addr_r     <= in_address;
      low_bits_r <= dividend[STEP_BITS-1:0];
      div_r      <= div_nxt;
      rem_r      <= rem_step('0, dividend[2*STEP_BITS-1:STEP_BITS], div_nxt);
    end
  end

  // second remainder step and address assembly
  assign rem_final  = rem_step(rem_r, low_bits_r, div_r);
  assign bank_final = bypass_r ? (prg_cnt_r - 1'b1) : rem_final;

  always_comb begin
    case (kind_r)
      KIND_PRG:  mapped_nxt = {bank_final, addr_r[13:0]};
      KIND_CHR8: mapped_nxt = {2'b00, bank_final[6:0], addr_r[12:0]};
      KIND_CHR4: mapped_nxt = {2'b00, bank_final, addr_r[11:0]};
      KIND_RAW:  mapped_nxt = {{(MAP_W-ADDR_W){1'b0}}, addr_r};
      default:   mapped_nxt = '0;
    endcase
  end

  always_comb begin
    if (ctrl_written_r) begin
      mir_nxt = {1'b0, ctrl_r[1:0]};
    end else begin
      mir_nxt = (hdr_mir_r > MIR_FOUR) ? MIR_FOUR : hdr_mir_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_claimed_r    <= claimed_r;
      out_addr_valid_r <= (kind_r != KIND_NONE);
      out_mapped_r     <= mapped_nxt;
      out_mir_r        <= mir_nxt;
    end
  end

  assign status.slot_free   = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_claimed        = out_claimed_r;
  assign out_address_valid  = out_addr_valid_r;
  assign out_mapped_address = out_mapped_r;
  assign out_mirroring      = out_mir_r;

endmodule

`default_nettype wire

[rtl/core/serial_loaded_bank_mapper_unit.sv]
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_unit
// Serial-loaded PRG/CHR bank mapper: claims and maps CPU and PPU accesses.
// ----------------------------------------------------------------------------
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------------------
//   in_ch    | in  | operation, address, data (one bus access)
//   out_ch   | out | claimed, address_valid, mapped_address, mirroring
//   cfg_*    | in  | write enable, register index, write data (no read-back)
//
// The accept cycle decodes the access and runs the upper half of the bank
// remainder into the job registers; the lower half runs from them as the
// output register loads. The remainder unit (bank mod bank count) takes three
// bits per step. A new beat is taken only once the last result is in the output
// register, and a stall on out_ch holds the block after its current beat.
// Reset is synchronous; after it the mapper holds the power-on register set.
//
`default_nettype none

module serial_loaded_bank_mapper_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  sblm_in_if.sink                         in_ch,
  sblm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sblm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sblm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sblm_pkg::*;

  sblm_cmd_t    cmd;
  sblm_status_t status;
  logic         in_ready;

  // Sequencer: accept one beat, then release its result when the slot frees.
  sblm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath: registers, decode, remainder and the output register that
  // parts the two channels.
  sblm_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_ch.operation),
    .in_address         (in_ch.address),
    .in_data            (in_ch.data),
    .cmd                (cmd),
    .status             (status),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_claimed        (out_ch.claimed),
    .out_address_valid  (out_ch.address_valid),
    .out_mapped_address (out_ch.mapped_address),
    .out_mirroring      (out_ch.mirroring)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

[rtl/core/sblm_checker.sv]
// ----------------------------------------------------------------------------
// sblm_checker
// Port-level checks for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_loaded_bank_mapper_unit_defines.svh"

module sblm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_claimed,
  input logic                       out_address_valid,
  input logic [sblm_pkg::MAP_W-1:0] out_mapped_address
);
  import sblm_pkg::*;

  // a pending result stays until taken
  `SBLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one access at a time: ready drops right after a beat is taken
  `SBLM_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // a mapped address only comes with a claimed access
  `SBLM_ASSERT_IMPL(a_valid_claimed, clk, rst_n, out_valid && out_address_valid, out_claimed)

  // no mapping means a zero address
  `SBLM_ASSERT_IMPL(a_zero_addr, clk, rst_n, out_valid && !out_address_valid,
                    out_mapped_address == '0)

endmodule

bind serial_loaded_bank_mapper_unit sblm_checker u_sblm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_claimed        (out_ch.claimed),
  .out_address_valid  (out_ch.address_valid),
  .out_mapped_address (out_ch.mapped_address)
);

`default_nettype wire
